// ===== rtl/key_sequence_map_table_defines.svh =====
// Assertion macros shared by the key sequence map table RTL.
// Depends on a clock named clk and a synchronous reset named rst in the including scope.
`ifndef KEY_SEQUENCE_MAP_TABLE_DEFINES_SVH
`define KEY_SEQUENCE_MAP_TABLE_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define KSM_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Condition that, when true, implies a consequence in the next cycle.
`define KSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ksm_pkg.sv =====
// Package for the key sequence map table: sizes, codes and controller/datapath structs.
// Used by the top level, the controller and the datapath; depends on nothing.
package ksm_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int KEY_BYTES   = 16;
  localparam int VALUE_BYTES = 64;
  localparam int VALUE_CAP   = 255;

  // Value bytes that the stage keeps.
  localparam int VSTAGE_LIM = (VALUE_BYTES < VALUE_CAP) ? VALUE_BYTES : VALUE_CAP;

  localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int KLEN_W = $clog2(KEY_BYTES + 1);
  localparam int KOFF_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int VLEN_W = $clog2(VSTAGE_LIM + 1);
  localparam int VOFF_W = (VSTAGE_LIM > 1) ? $clog2(VSTAGE_LIM) : 1;

  localparam int KRAM_DEPTH = MAX_ENTRIES << KOFF_W;
  localparam int VRAM_DEPTH = MAX_ENTRIES << VOFF_W;

  // Fixed field widths of the ports.
  localparam int OP_W   = 3;
  localparam int ST_W   = 3;
  localparam int CONS_W = 5;
  localparam int WORD_W = 64;
  localparam int NB_W   = 4;

  typedef enum logic [OP_W-1:0] {
    OP_STAGE_KEY,
    OP_STAGE_VALUE,
    OP_ADD,
    OP_REMOVE,
    OP_LOOKUP,
    OP_PREFIX
  } opcode_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK,
    ST_NOT_FOUND,
    ST_FULL,
    ST_EMPTY_KEY,
    ST_KEY_LONG
  } status_code_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ANS,
    S_ENT,
    S_KRD,
    S_KCMP,
    S_SDONE,
    S_KWR,
    S_VRD,
    S_VWR,
    S_VSTART,
    S_VRDO,
    S_VGET,
    S_VOUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic         stage_key;
    logic         stage_val;
    logic         latch;
    logic         srch_init;
    logic         ent_next;
    logic         ent_take;
    logic         byte_next;
    logic         rec_match;
    logic         prefix;
    logic         new_init;
    logic         kwr;
    logic         meta_new;
    logic         vwr;
    logic         meta_val;
    logic         rm;
    logic         b_clr;
    logic         emit_get;
    logic         out_load;
    logic         with_value;
    status_code_t code;
    logic         clr_stage;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic overflow;
    logic kempty;
    logic ent_done;
    logic cand;
    logic byte_eq;
    logic j_last;
    logic hit;
    logic tfull;
    logic kcopy_done;
    logic vcopy_done;
    logic emit_done;
    logic vlen_zero;
    logic word_end;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/key_sequence_map_table.sv =====
// Top level of the key sequence map table: controller plus datapath.
// Depends on ksm_pkg, ksm_ctrl and ksm_dp.
//
// Staging a key or value byte does not stall the input. A command walks the entries in
// table order and reads each compared key byte of a candidate through the registered
// key RAM port. Add copies the key into a new slot when no entry matched, then copies
// the value through the value stage and value RAM; lookups emit the value bytes through
// the value RAM, up to eight per result. Remove closes the gap in the table order with a
// single register update. The next item is accepted once the last result is loaded into
// the output register, which may still wait to be taken. No clearing pass is needed.
module key_sequence_map_table (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ksm_pkg::OP_W-1:0]    opcode,
  input  logic [7:0]                  data_byte,
  input  logic                        insert_mode,
  input  logic                        no_remap,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ksm_pkg::ST_W-1:0]    status,
  output logic [ksm_pkg::CONS_W-1:0]  consumed,
  output logic [ksm_pkg::WORD_W-1:0]  value_word,
  output logic [ksm_pkg::NB_W-1:0]    valid_bytes,
  output logic                        entry_no_remap,
  output logic                        last
);
  import ksm_pkg::*;

  cmd_t  cmd;
  stat_t st;

  ksm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .opcode   (opcode),
    .st       (st),
    .cmd      (cmd)
  );

  ksm_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .data_byte      (data_byte),
    .insert_mode    (insert_mode),
    .no_remap       (no_remap),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .consumed       (consumed),
    .value_word     (value_word),
    .valid_bytes    (valid_bytes),
    .entry_no_remap (entry_no_remap),
    .last           (last)
  );

endmodule

// ===== rtl/ksm_ram.sv =====
// Generic single-port RAM with a registered read.
// Depends on nothing.
module ksm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read data registered; a read of the written address returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/ksm_ctrl.sv =====
// Controller state machine of the key sequence map table.
// Depends on ksm_pkg; drives the datapath through cmd_t and reads stat_t.
module ksm_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [ksm_pkg::OP_W-1:0] opcode,
  input  ksm_pkg::stat_t          st,
  output ksm_pkg::cmd_t           cmd
);
  import ksm_pkg::*;

  state_t       state, state_next;
  opcode_t      op_r, op_next;
  status_code_t code_r, code_next;

  // State, command and answer code registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      op_r   <= OP_STAGE_KEY;
      code_r <= ST_OK;
    end else begin
      state  <= state_next;
      op_r   <= op_next;
      code_r <= code_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    op_next    = op_r;
    code_next  = code_r;
    cmd        = '0;
    cmd.prefix = (op_r == OP_PREFIX);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (opcode_t'(opcode))
            OP_STAGE_KEY:   cmd.stage_key = 1'b1;
            OP_STAGE_VALUE: cmd.stage_val = 1'b1;
            OP_ADD, OP_REMOVE, OP_LOOKUP, OP_PREFIX: begin
              cmd.latch = 1'b1;
              op_next   = opcode_t'(opcode);
              if (st.overflow) begin
                code_next  = ST_KEY_LONG;
                state_next = S_ANS;
              end else if (st.kempty) begin
                code_next  = (opcode_t'(opcode) == OP_ADD) ? ST_EMPTY_KEY : ST_NOT_FOUND;
                state_next = S_ANS;
              end else begin
                cmd.srch_init = 1'b1;
                state_next    = S_ENT;
              end
            end
            default: ;
          endcase
        end
      end
      // Single-result answer without value.
      S_ANS: begin
        if (st.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.code      = code_r;
          cmd.clr_stage = 1'b1;
          state_next    = S_IDLE;
        end
      end
      // Walk the entries in table order.
      S_ENT: begin
        if (st.ent_done) begin
          state_next = S_SDONE;
        end else if (st.cand) begin
          cmd.ent_take = 1'b1;
          state_next   = S_KRD;
        end else begin
          cmd.ent_next = 1'b1;
        end
      end
      S_KRD: state_next = S_KCMP;
      // Compare one key byte of the candidate.
      S_KCMP: begin
        if (!st.byte_eq) begin
          cmd.ent_next = 1'b1;
          state_next   = S_ENT;
        end else if (st.j_last) begin
          cmd.rec_match = 1'b1;
          if (op_r == OP_PREFIX) begin
            cmd.ent_next = 1'b1;
            state_next   = S_ENT;
          end else begin
            state_next = S_SDONE;
          end
        end else begin
          cmd.byte_next = 1'b1;
          state_next    = S_KRD;
        end
      end
      // Act on the search result.
      S_SDONE: begin
        case (op_r)
          OP_ADD: begin
            if (st.hit) begin
              cmd.b_clr  = 1'b1;
              state_next = S_VRD;
            end else if (st.tfull) begin
              code_next  = ST_FULL;
              state_next = S_ANS;
            end else begin
              cmd.new_init = 1'b1;
              state_next   = S_KWR;
            end
          end
          OP_REMOVE: begin
            if (st.hit) begin
              cmd.rm    = 1'b1;
              code_next = ST_OK;
            end else begin
              code_next = ST_NOT_FOUND;
            end
            state_next = S_ANS;
          end
          default: begin
            if (st.hit) begin
              cmd.b_clr  = 1'b1;
              state_next = S_VSTART;
            end else begin
              code_next  = ST_NOT_FOUND;
              state_next = S_ANS;
            end
          end
        endcase
      end
      // Copy the staged key into a new slot.
      S_KWR: begin
        if (st.kcopy_done) begin
          cmd.meta_new = 1'b1;
          state_next   = S_VRD;
        end else begin
          cmd.kwr = 1'b1;
        end
      end
      // Copy the staged value into the slot.
      S_VRD: begin
        if (st.vcopy_done) begin
          cmd.meta_val = 1'b1;
          code_next    = ST_OK;
          state_next   = S_ANS;
        end else begin
          state_next = S_VWR;
        end
      end
      S_VWR: begin
        cmd.vwr    = 1'b1;
        state_next = S_VRD;
      end
      // Emit the value eight bytes per result.
      S_VSTART: state_next = st.vlen_zero ? S_VOUT : S_VRDO;
      S_VRDO:   state_next = S_VGET;
      S_VGET: begin
        cmd.emit_get = 1'b1;
        state_next   = st.word_end ? S_VOUT : S_VRDO;
      end
      S_VOUT: begin
        if (st.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.with_value = 1'b1;
          cmd.code       = ST_OK;
          if (st.emit_done) begin
            cmd.clr_stage = 1'b1;
            state_next    = S_IDLE;
          end else begin
            state_next = S_VRDO;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/ksm_dp.sv =====
// Datapath of the key sequence map table: stages, entry metadata, RAMs and result register.
// Depends on ksm_pkg, ksm_ram and the assertion macros header.
module ksm_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  ksm_pkg::cmd_t                cmd,
  output ksm_pkg::stat_t               st,
  input  logic [7:0]                   data_byte,
  input  logic                         insert_mode,
  input  logic                         no_remap,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ksm_pkg::ST_W-1:0]     status,
  output logic [ksm_pkg::CONS_W-1:0]   consumed,
  output logic [ksm_pkg::WORD_W-1:0]   value_word,
  output logic [ksm_pkg::NB_W-1:0]     valid_bytes,
  output logic                         entry_no_remap,
  output logic                         last
);
  import ksm_pkg::*;
  `include "key_sequence_map_table_defines.svh"

  // Staging.
  logic [7:0]        kstage [KEY_BYTES];
  logic [KLEN_W-1:0] kcount;
  logic              overflow;
  logic [VLEN_W-1:0] vcount;
  logic              mode_r, nr_r;

  // Table order and per-slot metadata.
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  order    [MAX_ENTRIES];
  logic              mode_mem [MAX_ENTRIES];
  logic              remap_mem[MAX_ENTRIES];
  logic [KLEN_W-1:0] klen_mem [MAX_ENTRIES];
  logic [VLEN_W-1:0] vlen_mem [MAX_ENTRIES];

  // Search and emit state.
  logic [CNT_W-1:0]  i;
  logic [KLEN_W-1:0] j;
  logic [IDX_W-1:0]  phys_c;
  logic [KLEN_W-1:0] kl_c;
  logic              hit;
  logic [IDX_W-1:0]  hit_idx;
  logic [IDX_W-1:0]  hit_phys;
  logic [KLEN_W-1:0] match_len;
  logic [VLEN_W-1:0] b;
  logic [NB_W-1:0]   nb;
  logic [WORD_W-1:0] word;

  logic [7:0] k_rdata, v_rdata, s_rdata;
  logic [IDX_W-1:0]  ord_i;
  logic              mdm;
  logic [KLEN_W-1:0] klm;
  logic [VLEN_W-1:0] vlen_hit;
  logic              out_free;

  assign ord_i    = order[i[IDX_W-1:0]];
  assign mdm      = mode_mem[ord_i];
  assign klm      = klen_mem[ord_i];
  assign vlen_hit = vlen_mem[hit_phys];
  assign out_free = !out_valid || !out_stall;

  // Status toward the controller.
  always_comb begin
    st.overflow   = overflow;
    st.kempty     = (kcount == '0);
    st.ent_done   = (i == count);
    if (cmd.prefix) begin
      st.cand = (mdm == mode_r) && (klm <= kcount) && (klm != '0) && (klm > match_len);
    end else begin
      st.cand = (mdm == mode_r) && (klm == kcount);
    end
    st.byte_eq    = (k_rdata == kstage[j[KOFF_W-1:0]]);
    st.j_last     = (KLEN_W'(j + 1'b1) == kl_c);
    st.hit        = hit;
    st.tfull      = (count == CNT_W'(MAX_ENTRIES));
    st.kcopy_done = (j == kcount);
    // Value copy ends at the staged count; emission ends at the stored length.
    st.vcopy_done = (b == vcount);
    st.emit_done  = (b == vlen_hit);
    st.vlen_zero  = (vlen_hit == '0);
    st.word_end   = (nb == NB_W'(7)) || (VLEN_W'(b + 1'b1) == vlen_hit);
    st.out_free   = out_free;
  end

  // Key RAM: one slot of KEY_BYTES per physical entry.
  logic                          k_we;
  logic [IDX_W+KOFF_W-1:0]       k_addr;
  assign k_we   = cmd.kwr;
  assign k_addr = cmd.kwr ? {hit_phys, j[KOFF_W-1:0]} : {phys_c, j[KOFF_W-1:0]};

  ksm_ram #(.WIDTH(8), .DEPTH(KRAM_DEPTH)) u_kram (
    .clk   (clk),
    .we    (k_we),
    .addr  (k_addr),
    .wdata (kstage[j[KOFF_W-1:0]]),
    .rdata (k_rdata)
  );

  // Value RAM: one slot of the value capacity per physical entry.
  ksm_ram #(.WIDTH(8), .DEPTH(VRAM_DEPTH)) u_vram (
    .clk   (clk),
    .we    (cmd.vwr),
    .addr  ({hit_phys, b[VOFF_W-1:0]}),
    .wdata (s_rdata),
    .rdata (v_rdata)
  );

  // Value stage memory.
  logic              s_we;
  logic [VOFF_W-1:0] s_addr;
  assign s_we   = cmd.stage_val && (vcount < VLEN_W'(VSTAGE_LIM));
  assign s_addr = cmd.stage_val ? vcount[VOFF_W-1:0] : b[VOFF_W-1:0];

  ksm_ram #(.WIDTH(8), .DEPTH(VSTAGE_LIM)) u_sram (
    .clk   (clk),
    .we    (s_we),
    .addr  (s_addr),
    .wdata (data_byte),
    .rdata (s_rdata)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      kcount     <= '0;
      overflow   <= 1'b0;
      vcount     <= '0;
      count      <= '0;
      out_valid  <= 1'b0;
      hit        <= 1'b0;
      for (int k = 0; k < MAX_ENTRIES; k++) begin
        order[k] <= IDX_W'(k);
      end
    end else begin
      // Staging.
      if (cmd.stage_key) begin
        if (kcount < KLEN_W'(KEY_BYTES)) begin
          kcount <= KLEN_W'(kcount + 1'b1);
        end else begin
          overflow <= 1'b1;
        end
      end
      if (s_we) begin
        vcount <= VLEN_W'(vcount + 1'b1);
      end
      if (cmd.clr_stage) begin
        kcount     <= '0;
        overflow   <= 1'b0;
        vcount     <= '0;
      end
      if (cmd.srch_init) begin
        hit <= 1'b0;
      end
      if (cmd.rec_match) begin
        hit <= 1'b1;
      end
      if (cmd.meta_new) begin
        count <= CNT_W'(count + 1'b1);
      end
      // Remove closes the gap in table order; the freed slot goes to the end.
      if (cmd.rm) begin
        for (int k = 0; k < MAX_ENTRIES; k++) begin
          if (CNT_W'(k) == CNT_W'(count - 1'b1)) begin
            order[k] <= hit_phys;
          end else if ((IDX_W'(k) >= hit_idx) && (CNT_W'(k) < CNT_W'(count - 1'b1))) begin
            order[k] <= order[(k + 1) % MAX_ENTRIES];
          end
        end
        count <= CNT_W'(count - 1'b1);
      end
      // Result register.
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.stage_key && (kcount < KLEN_W'(KEY_BYTES))) begin
      kstage[kcount[KOFF_W-1:0]] <= data_byte;
    end
    if (cmd.latch) begin
      mode_r <= insert_mode;
      nr_r   <= no_remap;
    end
    if (cmd.srch_init) begin
      i         <= '0;
      match_len <= '0;
    end
    if (cmd.ent_next) begin
      i <= CNT_W'(i + 1'b1);
    end
    if (cmd.ent_take) begin
      phys_c <= ord_i;
      kl_c   <= klm;
      j      <= '0;
    end
    if (cmd.byte_next || cmd.kwr) begin
      j <= KLEN_W'(j + 1'b1);
    end
    if (cmd.rec_match) begin
      hit_phys  <= phys_c;
      hit_idx   <= i[IDX_W-1:0];
      match_len <= kl_c;
    end
    if (cmd.new_init) begin
      hit_phys <= ord_i;
      j        <= '0;
      b        <= '0;
    end
    if (cmd.meta_new) begin
      mode_mem[hit_phys] <= mode_r;
      klen_mem[hit_phys] <= kcount;
    end
    if (cmd.meta_val) begin
      vlen_mem[hit_phys]  <= vcount;
      remap_mem[hit_phys] <= nr_r;
    end
    if (cmd.vwr) begin
      b <= VLEN_W'(b + 1'b1);
    end
    if (cmd.b_clr) begin
      b    <= '0;
      nb   <= '0;
      word <= '0;
    end
    if (cmd.emit_get) begin
      word[{nb[2:0], 3'b000} +: 8] <= v_rdata;
      nb <= NB_W'(nb + 1'b1);
      b  <= VLEN_W'(b + 1'b1);
    end
    if (cmd.out_load) begin
      status <= cmd.code;
      last   <= cmd.with_value ? st.emit_done : 1'b1;
      if (cmd.with_value) begin
        consumed       <= cmd.prefix ? CONS_W'(match_len) : '0;
        value_word     <= word;
        valid_bytes    <= nb;
        entry_no_remap <= remap_mem[hit_phys];
      end else begin
        consumed       <= '0;
        value_word     <= '0;
        valid_bytes    <= '0;
        entry_no_remap <= 1'b0;
      end
      word <= '0;
      nb   <= '0;
    end
  end

  `KSM_ASSERT(a_load_free, !cmd.out_load || out_free, "result loaded over a pending one")
  `KSM_ASSERT(a_count_max, count <= CNT_W'(MAX_ENTRIES), "entry count beyond table size")
  `KSM_ASSERT(a_kwr_bound, !cmd.kwr || (j < kcount), "key copy past staged length")
  `KSM_ASSERT_NEXT(a_rm_count, cmd.rm, count == CNT_W'($past(count) - 1'b1), "remove miscount")

endmodule

// ===== tb/tb_key_sequence_map_table.sv =====
// Self-checking testbench for the key sequence map table (add, remove, lookup, prefix match).
// Depends on ksm_pkg and key_sequence_map_table; a scoreboard class predicts every result.
`timescale 1ns / 100ps

module tb_key_sequence_map_table;
  import ksm_pkg::*;

  typedef struct {
    logic [ST_W-1:0]   status;
    logic [CONS_W-1:0] consumed;
    logic [WORD_W-1:0] value_word;
    logic [NB_W-1:0]   valid_bytes;
    logic              entry_no_remap;
    logic              last;
  } map_result_t;

  // Scoreboard: keeps a private copy of the table and the queue of predicted results.
  class map_table_scoreboard;
    bit             ent_mode[MAX_ENTRIES];
    bit             ent_nr[MAX_ENTRIES];
    int             ent_klen[MAX_ENTRIES];
    logic [7:0]     ent_key[MAX_ENTRIES][KEY_BYTES];
    int             ent_vlen[MAX_ENTRIES];
    logic [7:0]     ent_val[MAX_ENTRIES][VALUE_BYTES];
    int             ent_count;
    logic [7:0]     kstage[KEY_BYTES];
    int             kstage_len;
    bit             kstage_over;
    logic [7:0]     vstage[VALUE_BYTES];
    int             vstage_len;
    map_result_t    pending[$];
    int             errors;
    int             checked;
    int             hits;

    function void push(int st, int cons, logic [63:0] w, int nb, bit nr, bit lst);
      map_result_t r;
      r.status = ST_W'(st);
      r.consumed = CONS_W'(cons);
      r.value_word = w;
      r.valid_bytes = NB_W'(nb);
      r.entry_no_remap = nr;
      r.last = lst;
      pending.push_back(r);
    endfunction

    function int find_exact(bit mode);
      bit same;
      for (int i = 0; i < ent_count; i++) begin
        if (ent_mode[i] == mode && ent_klen[i] == kstage_len) begin
          same = 1;
          for (int b = 0; b < kstage_len; b++)
            if (ent_key[i][b] != kstage[b]) same = 0;
          if (same) return i;
        end
      end
      return -1;
    endfunction

    // Values leave eight bytes per result; an empty value still gives one result.
    function void emit_value(int idx, int cons);
      int nres;
      logic [63:0] w;
      int nb;
      nres = (ent_vlen[idx] == 0) ? 1 : (ent_vlen[idx] + 7) / 8;
      hits++;
      for (int k = 0; k < nres; k++) begin
        w = '0;
        nb = 0;
        for (int b = 0; b < 8 && k * 8 + b < ent_vlen[idx]; b++) begin
          w[8*b +: 8] = ent_val[idx][k*8+b];
          nb++;
        end
        push(ST_OK, cons, w, nb, ent_nr[idx], k + 1 == nres);
      end
    endfunction

    function void store_value(int idx, bit nr);
      for (int b = 0; b < vstage_len; b++) ent_val[idx][b] = vstage[b];
      ent_vlen[idx] = vstage_len;
      ent_nr[idx] = nr;
    endfunction

    // Notes one accepted input transaction and predicts what it causes.
    function void note(opcode_t op, logic [7:0] data, bit mode, bit nr);
      int idx;
      int best;
      int match_len;
      bit same;
      if (op == OP_STAGE_KEY) begin
        if (kstage_len < KEY_BYTES) kstage[kstage_len++] = data;
        else kstage_over = 1;
        return;
      end
      if (op == OP_STAGE_VALUE) begin
        if (vstage_len < VSTAGE_LIM) vstage[vstage_len++] = data;
        return;
      end
      if (kstage_over) begin
        push(ST_KEY_LONG, 0, 0, 0, 0, 1);
      end else if (op == OP_ADD) begin
        if (kstage_len == 0) begin
          push(ST_EMPTY_KEY, 0, 0, 0, 0, 1);
        end else begin
          idx = find_exact(mode);
          if (idx >= 0) begin
            store_value(idx, nr);
            push(ST_OK, 0, 0, 0, 0, 1);
          end else if (ent_count >= MAX_ENTRIES) begin
            push(ST_FULL, 0, 0, 0, 0, 1);
          end else begin
            for (int b = 0; b < kstage_len; b++) ent_key[ent_count][b] = kstage[b];
            ent_klen[ent_count] = kstage_len;
            ent_mode[ent_count] = mode;
            store_value(ent_count, nr);
            ent_count++;
            push(ST_OK, 0, 0, 0, 0, 1);
          end
        end
      end else if (op == OP_REMOVE) begin
        idx = (kstage_len == 0) ? -1 : find_exact(mode);
        if (idx < 0) begin
          push(ST_NOT_FOUND, 0, 0, 0, 0, 1);
        end else begin
          // Later entries move down one place to close the gap.
          for (int i = idx; i + 1 < ent_count; i++) begin
            ent_mode[i] = ent_mode[i+1];
            ent_nr[i] = ent_nr[i+1];
            ent_klen[i] = ent_klen[i+1];
            ent_vlen[i] = ent_vlen[i+1];
            ent_key[i] = ent_key[i+1];
            ent_val[i] = ent_val[i+1];
          end
          ent_count--;
          push(ST_OK, 0, 0, 0, 0, 1);
        end
      end else if (op == OP_LOOKUP) begin
        idx = (kstage_len == 0) ? -1 : find_exact(mode);
        if (idx < 0) push(ST_NOT_FOUND, 0, 0, 0, 0, 1);
        else emit_value(idx, 0);
      end else if (op == OP_PREFIX) begin
        // The longest key wins; on a tie the earliest entry stays.
        best = -1;
        match_len = 0;
        for (int i = 0; i < ent_count; i++) begin
          if (ent_mode[i] == mode && ent_klen[i] != 0 && ent_klen[i] <= kstage_len) begin
            same = 1;
            for (int b = 0; b < ent_klen[i]; b++)
              if (ent_key[i][b] != kstage[b]) same = 0;
            if (same && ent_klen[i] > match_len) begin
              match_len = ent_klen[i];
              best = i;
            end
          end
        end
        if (best < 0) push(ST_NOT_FOUND, 0, 0, 0, 0, 1);
        else emit_value(best, match_len);
      end else begin
        return;
      end
      kstage_len = 0;
      kstage_over = 0;
      vstage_len = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task check(map_result_t got);
      map_result_t exp;
      if (pending.size() == 0) begin
        report("result transaction with no prediction waiting");
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (got.status !== exp.status)
        report($sformatf("status %0d, predicted %0d", got.status, exp.status));
      if (got.consumed !== exp.consumed)
        report($sformatf("consumed %0d, predicted %0d", got.consumed, exp.consumed));
      if (got.value_word !== exp.value_word)
        report($sformatf("value_word %h, predicted %h", got.value_word, exp.value_word));
      if (got.valid_bytes !== exp.valid_bytes)
        report($sformatf("valid_bytes %0d, predicted %0d", got.valid_bytes,
                         exp.valid_bytes));
      if (got.entry_no_remap !== exp.entry_no_remap)
        report($sformatf("entry_no_remap %0b, predicted %0b", got.entry_no_remap,
                         exp.entry_no_remap));
      if (got.last !== exp.last)
        report($sformatf("last %0b, predicted %0b", got.last, exp.last));
    endtask
  endclass

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [OP_W-1:0]   opcode;
  logic [7:0]        data_byte;
  logic              insert_mode;
  logic              no_remap;
  logic              out_valid;
  logic              out_stall;
  logic [ST_W-1:0]   status;
  logic [CONS_W-1:0] consumed;
  logic [WORD_W-1:0] value_word;
  logic [NB_W-1:0]   valid_bytes;
  logic              entry_no_remap;
  logic              last;

  map_table_scoreboard table_sb;
  int                  sender_idle_pct;
  int                  stall_pct;
  int                  items_sent;
  int                  commands_sent;
  logic [7:0]          alphabet[4] = '{8'h61, 8'h62, 8'h9e, 8'h01};

  key_sequence_map_table dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .data_byte(data_byte), .insert_mode(insert_mode), .no_remap(no_remap),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .consumed(consumed), .value_word(value_word),
    .valid_bytes(valid_bytes), .entry_no_remap(entry_no_remap), .last(last)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver stalls at random with the rate of the current phase.
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Every result transaction goes to the scoreboard.
  always @(posedge clk) begin
    map_result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.status = status;
      got.consumed = consumed;
      got.value_word = value_word;
      got.valid_bytes = valid_bytes;
      got.entry_no_remap = entry_no_remap;
      got.last = last;
      table_sb.check(got);
    end
  end

  // Drives one input transaction and returns at the edge where it is accepted.
  task automatic send(opcode_t op, logic [7:0] data, bit mode, bit nr);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    data_byte <= data;
    insert_mode <= mode;
    no_remap <= nr;
    do @(posedge clk); while (in_stall);
    table_sb.note(op, data, mode, nr);
    items_sent++;
    if (op >= OP_ADD) commands_sent++;
  endtask

  task automatic stage_key(logic [7:0] k[$]);
    foreach (k[i]) send(OP_STAGE_KEY, k[i], 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  task automatic stage_value(int len);
    repeat (len) send(OP_STAGE_VALUE, 8'($urandom_range(255, 1)), 1'($urandom_range(1)),
                      1'($urandom_range(1)));
  endtask

  // Keys mostly come from a small alphabet so that commands find each other.
  function automatic void random_key(output logic [7:0] k[$], input int len, input bit wide);
    k = {};
    repeat (len) k.push_back(wide ? 8'($urandom_range(255, 1)) : alphabet[$urandom_range(3)]);
  endfunction

  // The sender goes idle until every predicted result has been taken.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (table_sb.pending.size() != 0) @(posedge clk);
  endtask

  // One well-formed command with random content, now and then a broken one.
  task automatic random_command();
    logic [7:0] k[$];
    int         pick;
    int         klen;
    int         vlen;
    opcode_t    op;
    pick = $urandom_range(99);
    klen = $urandom_range(99);
    if (klen < 75) klen = $urandom_range(3, 1);
    else if (klen < 88) klen = $urandom_range(6, 4);
    else if (klen < 94) klen = $urandom_range(KEY_BYTES, 7);
    else if (klen < 97) klen = KEY_BYTES + $urandom_range(3, 1);
    else klen = 0;
    random_key(k, klen, klen > 6 || $urandom_range(9) == 0);
    if (pick < 40) op = OP_ADD;
    else if (pick < 55) op = OP_REMOVE;
    else if (pick < 75) op = OP_LOOKUP;
    else op = OP_PREFIX;
    stage_key(k);
    if (op == OP_ADD || $urandom_range(9) == 0) begin
      vlen = $urandom_range(99);
      if (vlen < 80) vlen = $urandom_range(10);
      else if (vlen < 95) vlen = $urandom_range(24, 11);
      else vlen = $urandom_range(VALUE_BYTES + 6, VALUE_BYTES - 4);
      stage_value(vlen);
    end
    send(op, 8'($urandom_range(255, 1)), $urandom_range(9) < 3, 1'($urandom_range(1)));
  endtask

  initial begin
    logic [7:0] k[$];
    table_sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = OP_STAGE_KEY;
    data_byte = 8'h01;
    insert_mode = 1'b0;
    no_remap = 1'b0;
    sender_idle_pct = 0;
    stall_pct = 0;
    items_sent = 0;
    commands_sent = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty key on every command, an overlong key, exact and prefix hits.
    send(OP_ADD, 8'h01, 0, 0);
    send(OP_LOOKUP, 8'hff, 0, 0);
    send(OP_PREFIX, 8'h01, 1, 1);
    send(OP_REMOVE, 8'h01, 0, 0);
    random_key(k, KEY_BYTES + 1, 1);
    stage_key(k);
    send(OP_ADD, 8'h01, 0, 1);
    stage_key('{8'h61});
    stage_value(3);
    send(OP_ADD, 8'hff, 0, 1);
    stage_key('{8'h61, 8'h62});
    send(OP_ADD, 8'h01, 0, 0);
    stage_key('{8'h61, 8'h62, 8'hff});
    send(OP_PREFIX, 8'h01, 0, 0);
    stage_key('{8'h61});
    send(OP_LOOKUP, 8'h01, 0, 0);
    stage_key('{8'h61});
    send(OP_LOOKUP, 8'h01, 1, 0);
    stage_key('{8'h61});
    send(OP_REMOVE, 8'h01, 0, 0);
    stage_key('{8'h80});
    send(OP_PREFIX, 8'h01, 0, 0);

    // Random phases: no idling, sender idle, receiver stalling, then both.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 77; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 77; end
        default: begin sender_idle_pct = 17; stall_pct = 17; end
      endcase
      // In the second phase the table is filled past its limit.
      if (phase == 1) begin
        for (int i = 0; i <= MAX_ENTRIES; i++) begin
          stage_key('{8'(8'h40 + i)});
          send(OP_ADD, 8'h01, 1, i[0]);
        end
        // Hold off until every outstanding result has come back.
        wait_drained();
      end
      while (items_sent < 40 + (phase + 1) * 55) random_command();
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Covered %0d input transactions, %0d commands, %0d results checked,",
             items_sent, commands_sent, table_sb.checked);
    $display("with %0d value hits under four idling and stall mixes.", table_sb.hits);
    if (table_sb.errors == 0 && table_sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("Timeout with %0d results outstanding", table_sb.pending.size());
    $display("Verification failed");
    $finish;
  end

endmodule
